/* rtl/core/infix_to_postfix_converter_unit_assert.svh */
// Assertion macros used by the checker in itp_chk.sv.
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ITP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("itp assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ITP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("itp assertion failed");

`endif

/* rtl/core/itp_pkg.sv */
`timescale 1ns / 1ps

package itp_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	typedef logic [CNT_W-1:0] itp_cnt_t;
	typedef logic [2:0]       itp_code_t;

	// shift command broadcast along the stack chain
	typedef struct packed {
		logic push;
		logic pop;
	} itp_shift_t;

	localparam itp_code_t CODE_NONE = 3'd0;
	localparam itp_code_t CODE_OPEN = 3'd1;
	localparam itp_code_t CODE_ADD  = 3'd2;
	localparam itp_code_t CODE_SUB  = 3'd3;
	localparam itp_code_t CODE_MUL  = 3'd4;
	localparam itp_code_t CODE_DIV  = 3'd5;
	localparam itp_code_t CODE_MOD  = 3'd6;

	localparam logic [7:0] CHR_NUL   = 8'h00;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_MOD   = 8'h25;
	localparam logic [7:0] CHR_OPEN  = 8'h28;
	localparam logic [7:0] CHR_CLOSE = 8'h29;
	localparam logic [7:0] CHR_MUL   = 8'h2A;
	localparam logic [7:0] CHR_ADD   = 8'h2B;
	localparam logic [7:0] CHR_SUB   = 8'h2D;
	localparam logic [7:0] CHR_DIV   = 8'h2F;

	localparam logic [1:0] ERR_OK        = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
	localparam logic [1:0] ERR_UNM_CLOSE = 2'd2;
	localparam logic [1:0] ERR_UNM_OPEN  = 2'd3;

	function automatic itp_code_t char_to_code(input logic [7:0] c);
		itp_code_t r;
		case (c)
			CHR_OPEN: r = CODE_OPEN;
			CHR_ADD:  r = CODE_ADD;
			CHR_SUB:  r = CODE_SUB;
			CHR_MUL:  r = CODE_MUL;
			CHR_DIV:  r = CODE_DIV;
			CHR_MOD:  r = CODE_MOD;
			default:  r = CODE_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] code_to_char(input itp_code_t k);
		logic [7:0] r;
		case (k)
			CODE_OPEN: r = CHR_OPEN;
			CODE_ADD:  r = CHR_ADD;
			CODE_SUB:  r = CHR_SUB;
			CODE_MUL:  r = CHR_MUL;
			CODE_DIV:  r = CHR_DIV;
			CODE_MOD:  r = CHR_MOD;
			default:   r = CHR_NUL;
		endcase
		return r;
	endfunction

	function automatic logic is_binop(input itp_code_t k);
		return k inside {[CODE_ADD:CODE_MOD]};
	endfunction

	// 1 for * / %, 0 for + -
	function automatic logic prec_high(input itp_code_t k);
		return k inside {[CODE_MUL:CODE_MOD]};
	endfunction

endpackage

/* rtl/core/itp_cell.sv */
`timescale 1ns / 1ps

// One stack slot; push takes the left neighbor, pop takes the right one.
module itp_cell (
	input  logic                  clk,
	input  itp_pkg::itp_shift_t   shift,
	input  itp_pkg::itp_code_t    from_left,
	input  itp_pkg::itp_code_t    from_right,
	output itp_pkg::itp_code_t    code
);
	import itp_pkg::*;

	itp_code_t code_q;

	always_ff @(posedge clk) begin
		if (shift.push) begin
			code_q <= from_left;
		end else if (shift.pop) begin
			code_q <= from_right;
		end
	end

	assign code = code_q;

endmodule

/* rtl/core/infix_to_postfix_converter_unit.sv */
`timescale 1ns / 1ps

// Shunting-yard infix to postfix converter. Feed one ASCII character per
// transfer on in_char; postfix characters come out on out_char, one per
// transfer, with is_last marking the terminator (out_char 0) that closes
// an expression after a NUL input. Spaces are dropped. error_code flags a
// dropped push on a full stack (1), an unmatched ')' (2) and each
// unmatched '(' found at the end (3). A character is taken while idle and
// then worked in one step per cycle, with at most one stack pop or push
// and at most one emitted result per step; no new character is taken
// until its last step is done. Steps wait while the output register holds
// a result that has not been taken. The operator stack is a chain of
// STACK_DEPTH cells that shift together on every push or pop, top at
// cell 0.
module infix_to_postfix_converter_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       is_last,
	output logic [1:0] error_code
);
	import itp_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_PROC = 1'b1;

	logic       state_q;
	logic [7:0] cur_q;
	itp_cnt_t   cnt_q;

	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       is_last_q;
	logic [1:0] error_code_q;

	// stack chain
	itp_shift_t shift;
	itp_code_t  code_w [STACK_DEPTH];
	itp_code_t  top;
	itp_code_t  cur_code;

	// step decision
	logic       step;
	logic       empty;
	logic       full;
	logic       emit;
	logic       done;
	logic [7:0] e_char;
	logic       e_last;
	logic [1:0] e_err;

	assign top      = code_w[0];
	assign cur_code = char_to_code(cur_q);
	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q == CNT_W'(STACK_DEPTH));

	// a step runs only when the output slot is free or draining
	assign step     = (state_q == ST_PROC) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		shift.push = 1'b0;
		shift.pop  = 1'b0;
		emit       = 1'b0;
		done       = 1'b0;
		e_char     = cur_q;
		e_last     = 1'b0;
		e_err      = ERR_OK;
		if (cur_q == CHR_SPACE) begin
			done = 1'b1;
		end else if (cur_q == CHR_NUL) begin
			// flush, then terminator
			emit = 1'b1;
			if (!empty) begin
				shift.pop = 1'b1;
				e_char    = code_to_char(top);
				if (top == CODE_OPEN) begin
					e_err = ERR_UNM_OPEN;
				end
			end else begin
				e_char = CHR_NUL;
				e_last = 1'b1;
				done   = 1'b1;
			end
		end else if (cur_q == CHR_CLOSE) begin
			if (!empty) begin
				shift.pop = 1'b1;
				if (top == CODE_OPEN) begin
					done = 1'b1;
				end else begin
					emit   = 1'b1;
					e_char = code_to_char(top);
				end
			end else begin
				emit  = 1'b1;
				e_err = ERR_UNM_CLOSE;
				done  = 1'b1;
			end
		end else if (cur_code != CODE_NONE) begin
			// left-assoc: pop while top precedence >= incoming
			if (is_binop(cur_code) && !empty && is_binop(top) &&
			    (prec_high(top) || !prec_high(cur_code))) begin
				shift.pop = 1'b1;
				emit      = 1'b1;
				e_char    = code_to_char(top);
			end else if (full) begin
				emit  = 1'b1;
				e_err = ERR_OVERFLOW;
				done  = 1'b1;
			end else begin
				shift.push = 1'b1;
				done       = 1'b1;
			end
		end else begin
			emit = 1'b1;
			done = 1'b1;
		end
		if (!step) begin
			shift.push = 1'b0;
			shift.pop  = 1'b0;
		end
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		itp_code_t left_w;
		itp_code_t right_w;
		if (i == 0) begin : g_head
			assign left_w = cur_code;
		end else begin : g_body
			assign left_w = code_w[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_tail
			assign right_w = CODE_NONE;
		end else begin : g_inner
			assign right_w = code_w[i+1];
		end
		itp_cell u_cell (
			.clk        (clk),
			.shift      (shift),
			.from_left  (left_w),
			.from_right (right_w),
			.code       (code_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_PROC;
					end
				end
				ST_PROC: begin
					if (step && done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (shift.push) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (shift.pop) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (step && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cur_q <= in_char;
		end
		if (step && emit) begin
			out_char_q   <= e_char;
			is_last_q    <= e_last;
			error_code_q <= e_err;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign is_last    = is_last_q;
	assign error_code = error_code_q;

endmodule

/* rtl/core/itp_chk.sv */
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_unit_assert.svh"

// Port-level checks on the converter's result stream.
module itp_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       is_last,
	input logic [1:0] error_code
);
	import itp_pkg::*;

	// stalled result holds
	`ITP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(is_last) && $stable(error_code))
	// terminator is a clean NUL
	`ITP_ASSERT_IMP(a_last_nul, out_valid && is_last, out_char == CHR_NUL && error_code == ERR_OK)
	// unmatched open reports '('
	`ITP_ASSERT_IMP(a_unm_open, out_valid && error_code == ERR_UNM_OPEN, out_char == CHR_OPEN && !is_last)
	// unmatched close reports ')'
	`ITP_ASSERT_IMP(a_unm_close, out_valid && error_code == ERR_UNM_CLOSE, out_char == CHR_CLOSE && !is_last)

endmodule

bind infix_to_postfix_converter_unit itp_chk u_itp_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_char   (out_char),
	.is_last    (is_last),
	.error_code (error_code)
);

/* tb/tb_infix_to_postfix_converter_unit.sv */
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter_unit;
	import itp_pkg::*;

	// one postfix character as it leaves the block
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic [1:0] err;
	} postfix_item_t;

	// Shunting-yard predictor plus the queue of postfix characters it expects.
	class postfix_scoreboard;
		itp_code_t     op_stack [STACK_DEPTH];
		int            op_depth;
		postfix_item_t expected_q [$];
		int            mismatches;

		function new();
			op_depth   = 0;
			mismatches = 0;
		endfunction

		static function itp_code_t code_for(logic [7:0] c);
			case (c)
				CHR_OPEN: return CODE_OPEN;
				CHR_ADD:  return CODE_ADD;
				CHR_SUB:  return CODE_SUB;
				CHR_MUL:  return CODE_MUL;
				CHR_DIV:  return CODE_DIV;
				CHR_MOD:  return CODE_MOD;
				default:  return CODE_NONE;
			endcase
		endfunction

		function logic [7:0] char_for(itp_code_t k);
			case (k)
				CODE_OPEN: return CHR_OPEN;
				CODE_ADD:  return CHR_ADD;
				CODE_SUB:  return CHR_SUB;
				CODE_MUL:  return CHR_MUL;
				CODE_DIV:  return CHR_DIV;
				CODE_MOD:  return CHR_MOD;
				default:   return CHR_NUL;
			endcase
		endfunction

		// binding strength: * / % above + -, '(' lowest
		function int rank(itp_code_t k);
			if (k == CODE_MUL || k == CODE_DIV || k == CODE_MOD)
				return 2;
			if (k == CODE_ADD || k == CODE_SUB)
				return 1;
			return 0;
		endfunction

		function void emit(logic [7:0] c, logic last, logic [1:0] err);
			postfix_item_t r;
			r.ch   = c;
			r.last = last;
			r.err  = err;
			expected_q.push_back(r);
		endfunction

		function void push_op(itp_code_t k, logic [7:0] c);
			if (op_depth >= STACK_DEPTH) begin
				emit(c, 1'b0, ERR_OVERFLOW);
			end else begin
				op_stack[op_depth] = k;
				op_depth++;
			end
		endfunction

		// called once per accepted input transfer
		function void note_char(logic [7:0] c);
			itp_code_t k;
			itp_code_t top;
			logic      found;
			if (c == CHR_SPACE)
				return;
			k = code_for(c);
			if (c == CHR_NUL) begin
				while (op_depth > 0) begin
					op_depth--;
					top = op_stack[op_depth];
					if (top == CODE_OPEN)
						emit(CHR_OPEN, 1'b0, ERR_UNM_OPEN);
					else
						emit(char_for(top), 1'b0, ERR_OK);
				end
				emit(CHR_NUL, 1'b1, ERR_OK);
			end else if (c == CHR_CLOSE) begin
				found = 1'b0;
				while (op_depth > 0 && !found) begin
					op_depth--;
					top = op_stack[op_depth];
					if (top == CODE_OPEN)
						found = 1'b1;
					else
						emit(char_for(top), 1'b0, ERR_OK);
				end
				if (!found)
					emit(CHR_CLOSE, 1'b0, ERR_UNM_CLOSE);
			end else if (k == CODE_OPEN) begin
				push_op(k, c);
			end else if (k != CODE_NONE) begin
				// left-associative: pop equal or higher, stop at '('
				while (op_depth > 0 && op_stack[op_depth-1] != CODE_OPEN &&
				       rank(op_stack[op_depth-1]) >= rank(k)) begin
					op_depth--;
					emit(char_for(op_stack[op_depth]), 1'b0, ERR_OK);
				end
				push_op(k, c);
			end else begin
				emit(c, 1'b0, ERR_OK);
			end
		endfunction

		function void complain(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		// called once per accepted output transfer
		function void check_result(logic [7:0] c, logic last, logic [1:0] err);
			postfix_item_t want;
			if (expected_q.size() == 0) begin
				complain($sformatf("unexpected result char %h last %b err %0d",
					c, last, err));
			end else begin
				want = expected_q.pop_front();
				if (want.ch !== c || want.last !== last || want.err !== err)
					complain($sformatf("mismatch: want char %h last %b err %0d, got %h %b %0d",
						want.ch, want.last, want.err, c, last, err));
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_char;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_char;
	logic       is_last;
	logic [1:0] error_code;

	postfix_scoreboard sb = new();

	logic [7:0] expr_q [$];      // characters waiting to be sent
	int         sent_items = 0;  // accepted non-space characters
	bit         quiet = 1'b0;    // no idling once set
	bit         hold_now = 1'b0; // asks the receiver for one long hold-off
	bit         hold_done = 1'b0;

	logic [7:0] binops [5] = '{CHR_ADD, CHR_SUB, CHR_MUL, CHR_DIV, CHR_MOD};
	logic [7:0] specials [10] = '{CHR_NUL, CHR_SPACE, CHR_OPEN, CHR_CLOSE, CHR_ADD,
	                              CHR_SUB, CHR_MUL, CHR_DIV, CHR_MOD, 8'h61};

	infix_to_postfix_converter_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_char    (in_char),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.is_last    (is_last),
		.error_code (error_code)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// any byte that is not NUL, space, a parenthesis or an operator
	function automatic logic [7:0] pick_operand();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CHR_NUL || c == CHR_SPACE || c == CHR_CLOSE ||
		       postfix_scoreboard::code_for(c) != CODE_NONE);
		return c;
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			expr_q.push_back(s[i]);
	endfunction

	// Well-formed infix with random nesting (max 6 deep, so no overflow).
	// Unbalanced leaves opens on the stack for the NUL flush to flag.
	function automatic void build_expr(int terms, bit balanced);
		int open_n;
		open_n = 0;
		for (int i = 0; i < terms; i++) begin
			while ($urandom_range(0, 3) == 0 && open_n < 6) begin
				expr_q.push_back(CHR_OPEN);
				open_n++;
			end
			expr_q.push_back(pick_operand());
			while (open_n > 0 && $urandom_range(0, 2) == 0) begin
				expr_q.push_back(CHR_CLOSE);
				open_n--;
			end
			if (i < terms - 1)
				expr_q.push_back(binops[$urandom_range(0, 4)]);
			if ($urandom_range(0, 7) == 0)
				expr_q.push_back(CHR_SPACE);
		end
		if (balanced)
			repeat (open_n) expr_q.push_back(CHR_CLOSE);
		expr_q.push_back(CHR_NUL);
	endfunction

	// Nesting from just under to past the stack depth: overflow on '(' and on operators when deep enough.
	function automatic void build_deep();
		int n;
		n = $urandom_range(29, 36);
		repeat (n) expr_q.push_back(CHR_OPEN);
		expr_q.push_back(pick_operand());
		expr_q.push_back(binops[$urandom_range(0, 4)]);
		expr_q.push_back(pick_operand());
		expr_q.push_back(binops[$urandom_range(0, 4)]);
		expr_q.push_back(pick_operand());
		repeat ($urandom_range(0, n)) expr_q.push_back(CHR_CLOSE);
		expr_q.push_back(CHR_NUL);
	endfunction

	// One input transfer, with an optional idle burst ahead of it.
	task automatic send_char(input logic [7:0] c);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_char  <= c;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_char(c);
		if (c != CHR_SPACE)
			sent_items++;
		// long receiver stall once, mid-run; sender keeps pushing
		if (!hold_done && sent_items >= 150) begin
			hold_done = 1'b1;
			hold_now  = 1'b1;
		end
		if (sent_items >= 320)
			quiet = 1'b1;
	endtask

	task automatic send_queue();
		while (expr_q.size() != 0)
			send_char(expr_q.pop_front());
	endtask

	// Receiver side: random stall bursts, runs of plain ready, and one long hold.
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_now) begin
				hold_now = 1'b0;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Every output transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_char, is_last, error_code);
	end

	initial begin
		int kind;
		int expr_n;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_char  = 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: equal-precedence chains pop left to right, mixed levels,
		// parenthesized group, all-ones byte as operand, a stray ')' on an
		// empty stack, opens left over at the end, and an empty expression.
		push_text("a-b*c+d");
		expr_q.push_back(CHR_NUL);
		push_text("(e/f)%g");
		expr_q.push_back(CHR_NUL);
		expr_q.push_back(CHR_SPACE);
		expr_q.push_back(8'hFF);
		expr_q.push_back(CHR_CLOSE);
		expr_q.push_back(CHR_NUL);
		push_text("((");
		expr_q.push_back(8'h80);
		expr_q.push_back(CHR_NUL);
		expr_q.push_back(CHR_NUL);
		send_queue();

		// Random: mostly well-formed expressions, some broken ones, noise
		// (which may leave state for the next expression) and deep nesting.
		expr_n = 0;
		while (sent_items < 380) begin
			kind = $urandom_range(0, 15);
			if (expr_n < 2 || kind == 15) begin
				build_deep();
			end else if (kind < 9) begin
				build_expr($urandom_range(1, 8), 1'b1);
			end else if (kind < 11) begin
				build_expr($urandom_range(1, 6), 1'b0);
			end else if (kind < 13) begin
				int start;
				start = expr_q.size();
				build_expr($urandom_range(1, 6), 1'b1);
				expr_q.insert($urandom_range(start, expr_q.size() - 1), CHR_CLOSE);
			end else begin
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(0, 1) == 0)
						expr_q.push_back(specials[$urandom_range(0, 9)]);
					else
						expr_q.push_back(8'($urandom_range(0, 255)));
				end
				if ($urandom_range(0, 1) == 0)
					expr_q.push_back(CHR_NUL);
			end
			send_queue();
			expr_n++;
		end
		in_valid <= 1'b0;

		// drain, then allow the longest flush to show any extra result
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog, well beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
